/* design/brbf_pkg.sv */
// Shared types and constants for the byte ring buffer FIFO.
package brbf_pkg;

    // fixed field widths
    localparam int FILL_W  = 11;
    localparam int CNT_W   = 7;
    localparam int WLEN_W  = 4;
    localparam int KIND_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int WDATA_W = 64;

    // stream payload widths
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESET = 2'd2;

    // result status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_CAP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_EMIT
    } t_state;

endpackage

/* design/brbf_ram.sv */
// Generic single-port RAM with registered read data.
module brbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read data holds while the port is not enabled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/byte_ring_buffer_fifo_unit.sv */
// Top level of the byte ring buffer FIFO: control, positions and result register.
//
//  channel  | dir | handshake                      | payload
//  ---------+-----+--------------------------------+------------------------------------
//  s_axis   | in  | i_s_axis_tvalid/o_s_axis_tready| tdata: write_data, write_length,
//           |     |                                |   read_length; tuser: kind
//  m_axis   | out | o_m_axis_tvalid/i_m_axis_tready| tdata: read_byte, moved_count,
//           |     |                                |   fill_level, free_space, is_empty
//           |     |                                |   tuser: status, byte_valid; tlast
//  cfg      | in  | i_cfg_valid/o_cfg_ready        | buffer_size
//
// A write of L bytes is accepted, then stores one byte per cycle into the single-port
// store, then gives its result; a read of N bytes fetches its first byte with the accept
// and then passes one byte per cycle to the output while it drains, as set by the store's single read port.
// Reset, no-op, empty-read and refused or zero-length write items each give a single result.
// Output stalls hold the read sequence in place; a new item is accepted once the
// previous one has loaded its last result into the output register.
// Reset clears positions and fill count and sets the size to 1024; the store itself
// is not cleared.
module byte_ring_buffer_fifo_unit #(
    parameter int DEPTH       = 1024,
    parameter int MAX_READ    = 64,
    parameter int WRITE_BYTES = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // cfg: buffer_size
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [brbf_pkg::FILL_W-1:0]     i_cfg_data,
    // tdata: write_data[63:0], write_length[67:64], read_length[74:68], zero pad
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [brbf_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: kind[1:0]
    input  logic [brbf_pkg::KIND_W-1:0]     i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tdata: read_byte[7:0], moved_count[14:8], fill_level[25:15],
    //        free_space[36:26], is_empty[37], zero pad
    output logic [brbf_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    // tuser: status[0], byte_valid[1]
    output logic [brbf_pkg::M_TUSER_W-1:0]  o_m_axis_tuser,
    output logic                            o_m_axis_tlast
);

    localparam int PW       = $clog2(DEPTH);
    localparam int CW       = (PW > brbf_pkg::FILL_W ? PW : brbf_pkg::FILL_W) + 1;
    localparam int SIZE_MAX = (1 << brbf_pkg::FILL_W) - 1;
    localparam int SIZE_CAP = DEPTH < SIZE_MAX ? DEPTH : SIZE_MAX;
    localparam int FW       = brbf_pkg::FILL_W;
    localparam int NW       = brbf_pkg::CNT_W;
    localparam int LW       = brbf_pkg::WLEN_W;

    brbf_pkg::t_state r_state, n_state;

    logic [FW-1:0]                 r_size,    n_size;
    logic [PW-1:0]                 r_rd_pos,  n_rd_pos;
    logic [PW-1:0]                 r_wr_pos,  n_wr_pos;
    logic [FW-1:0]                 r_fill,    n_fill;
    logic [NW-1:0]                 r_cnt,     n_cnt;
    logic [brbf_pkg::WDATA_W-1:0]  r_data,    n_data;
    logic                          r_status,  n_status;
    logic [NW-1:0]                 r_moved,   n_moved;

    logic                          r_out_valid;
    logic                          r_out_status;
    logic                          r_out_bvalid;
    logic [brbf_pkg::BYTE_W-1:0]   r_out_byte;
    logic                          r_out_last;
    logic [NW-1:0]                 r_out_moved;
    logic [FW-1:0]                 r_out_fill;
    logic [FW-1:0]                 r_out_free;
    logic                          r_out_empty;

    logic                          in_fire;
    logic                          cfg_fire;
    logic                          can_load;
    logic                          out_load;
    logic                          ld_bvalid;
    logic                          ld_last;

    logic [brbf_pkg::KIND_W-1:0]   in_kind;
    logic [brbf_pkg::WDATA_W-1:0]  in_wdata;
    logic [LW-1:0]                 in_wlen;
    logic [NW-1:0]                 in_rlen;
    logic [LW-1:0]                 wlen_sat;
    logic [NW-1:0]                 rlen_sat;
    logic [NW-1:0]                 rd_n;
    logic                          wr_ok;

    logic [CW-1:0]                 eff_size;
    logic [FW-1:0]                 free_now;
    logic [PW-1:0]                 rd_inc;
    logic [PW-1:0]                 wr_inc;

    logic                          ram_en;
    logic                          ram_we;
    logic [PW-1:0]                 ram_addr;
    logic [brbf_pkg::BYTE_W-1:0]   ram_wdata;
    logic [brbf_pkg::BYTE_W-1:0]   ram_rdata;

    brbf_ram #(
        .WIDTH (brbf_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign in_kind  = i_s_axis_tuser;
    assign in_wdata = i_s_axis_tdata[63:0];
    assign in_wlen  = i_s_axis_tdata[67:64];
    assign in_rlen  = i_s_axis_tdata[74:68];

    assign o_s_axis_tready = (r_state == brbf_pkg::ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_fire = i_cfg_valid;
    assign can_load = !r_out_valid || i_m_axis_tready;

    // size 0 acts as 1, sizes beyond the store clamp to its depth
    assign eff_size = (r_size == '0) ? CW'(1) :
                      ((CW'(r_size) > CW'(SIZE_CAP)) ? CW'(SIZE_CAP) : CW'(r_size));
    assign free_now = FW'(eff_size - CW'(r_fill));

    assign rd_inc = (CW'(r_rd_pos) + CW'(1) >= eff_size) ? '0 : r_rd_pos + PW'(1);
    assign wr_inc = (CW'(r_wr_pos) + CW'(1) >= eff_size) ? '0 : r_wr_pos + PW'(1);

    assign wlen_sat = (32'(in_wlen) > WRITE_BYTES) ? LW'(WRITE_BYTES) : in_wlen;
    assign rlen_sat = (32'(in_rlen) > MAX_READ) ? NW'(MAX_READ) : in_rlen;
    assign rd_n     = (r_fill < FW'(rlen_sat)) ? r_fill[NW-1:0] : rlen_sat;
    assign wr_ok    = (free_now >= FW'(wlen_sat));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            brbf_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (in_kind == brbf_pkg::KIND_WRITE && wr_ok && wlen_sat != '0) begin
                        n_state = brbf_pkg::ST_WRITE;
                    end else if (in_kind == brbf_pkg::KIND_READ && rd_n != '0) begin
                        n_state = brbf_pkg::ST_READ;
                    end else begin
                        n_state = brbf_pkg::ST_EMIT;
                    end
                end
            end
            brbf_pkg::ST_WRITE: begin
                if (r_cnt == NW'(1)) begin
                    n_state = brbf_pkg::ST_EMIT;
                end
            end
            brbf_pkg::ST_READ: begin
                if (can_load && r_cnt == NW'(1)) begin
                    n_state = brbf_pkg::ST_IDLE;
                end
            end
            brbf_pkg::ST_EMIT: begin
                if (can_load) begin
                    n_state = brbf_pkg::ST_IDLE;
                end
            end
            default: n_state = brbf_pkg::ST_IDLE;
        endcase
    end

    // datapath and store control
    always_comb begin
        n_size    = r_size;
        n_rd_pos  = r_rd_pos;
        n_wr_pos  = r_wr_pos;
        n_fill    = r_fill;
        n_cnt     = r_cnt;
        n_data    = r_data;
        n_status  = r_status;
        n_moved   = r_moved;
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = r_rd_pos;
        ram_wdata = r_data[brbf_pkg::BYTE_W-1:0];
        out_load  = 1'b0;
        ld_bvalid = 1'b0;
        ld_last   = 1'b1;

        case (r_state)
            brbf_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_status = brbf_pkg::STATUS_OK;
                    n_moved  = '0;
                    case (in_kind)
                        brbf_pkg::KIND_WRITE: begin
                            if (!wr_ok) begin
                                n_status = brbf_pkg::STATUS_CAP;
                            end else begin
                                n_moved = NW'(wlen_sat);
                                n_cnt   = NW'(wlen_sat);
                                n_data  = in_wdata;
                                n_fill  = r_fill + FW'(wlen_sat);
                            end
                        end
                        brbf_pkg::KIND_READ: begin
                            n_moved = rd_n;
                            n_cnt   = rd_n;
                            n_fill  = r_fill - FW'(rd_n);
                            // first byte fetch goes out with the accept
                            if (rd_n != '0) begin
                                ram_en   = 1'b1;
                                n_rd_pos = rd_inc;
                            end
                        end
                        brbf_pkg::KIND_RESET: begin
                            n_rd_pos = '0;
                            n_wr_pos = '0;
                            n_fill   = '0;
                        end
                        default: ;
                    endcase
                end
            end
            brbf_pkg::ST_WRITE: begin
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                ram_addr = r_wr_pos;
                n_wr_pos = wr_inc;
                n_data   = r_data >> brbf_pkg::BYTE_W;
                n_cnt    = r_cnt - NW'(1);
            end
            brbf_pkg::ST_READ: begin
                if (can_load) begin
                    out_load  = 1'b1;
                    ld_bvalid = 1'b1;
                    ld_last   = (r_cnt == NW'(1));
                    if (r_cnt != NW'(1)) begin
                        ram_en   = 1'b1;
                        n_rd_pos = rd_inc;
                        n_cnt    = r_cnt - NW'(1);
                    end
                end
            end
            brbf_pkg::ST_EMIT: begin
                out_load = can_load;
            end
            default: ;
        endcase

        // a size change clears the ring
        if (cfg_fire) begin
            n_size   = i_cfg_data;
            n_rd_pos = '0;
            n_wr_pos = '0;
            n_fill   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= brbf_pkg::ST_IDLE;
            r_size      <= FW'(1024);
            r_rd_pos    <= '0;
            r_wr_pos    <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_size   <= n_size;
            r_rd_pos <= n_rd_pos;
            r_wr_pos <= n_wr_pos;
            r_fill   <= n_fill;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_data   <= n_data;
        r_status <= n_status;
        r_moved  <= n_moved;
        if (out_load) begin
            r_out_status <= r_status;
            r_out_bvalid <= ld_bvalid;
            r_out_byte   <= ld_bvalid ? ram_rdata : '0;
            r_out_last   <= ld_last;
            r_out_moved  <= r_moved;
            r_out_fill   <= r_fill;
            r_out_free   <= free_now;
            r_out_empty  <= (r_fill == '0);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = {r_out_bvalid, r_out_status};
    assign o_m_axis_tdata  = {2'b00, r_out_empty, r_out_free, r_out_fill,
                              r_out_moved, r_out_byte};

endmodule

/* design/brbf_checker.sv */
// Port-level assertions for the byte ring buffer FIFO, bound to the top level.
module brbf_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [brbf_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    input logic [brbf_pkg::M_TUSER_W-1:0]  o_m_axis_tuser,
    input logic                            o_m_axis_tlast
);

    // a stalled result holds its payload
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    // empty flag agrees with the fill level
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[37] == (o_m_axis_tdata[25:15] == 11'd0)))
        else $error("empty flag disagrees with fill level");

    // a refused write is a lone result that moved nothing
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
            o_m_axis_tlast && !o_m_axis_tuser[1] && o_m_axis_tdata[14:8] == 7'd0)
        else $error("refused write result malformed");

    // a result without a byte closes its item and carries a zero byte
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[1] |->
            o_m_axis_tlast && o_m_axis_tdata[7:0] == 8'd0)
        else $error("byteless result not last or nonzero");

endmodule

bind byte_ring_buffer_fifo_unit brbf_checker u_brbf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

/* verif/tb_byte_ring_buffer_fifo_unit.sv */
// Self-checking testbench for the byte ring buffer FIFO unit: directed and random traffic.
`timescale 1ns / 1ps

module tb_byte_ring_buffer_fifo_unit;

    localparam int RING_DEPTH   = 1024;
    localparam int READ_MAX     = 64;
    localparam int WRITE_MAX    = 8;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int SHOW_MAX     = 10;

    // kind value the block treats as a no-op
    localparam logic [brbf_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic                        status;
        logic [brbf_pkg::BYTE_W-1:0] rbyte;
        logic                        bvalid;
        logic                        last;
        logic [brbf_pkg::CNT_W-1:0]  moved;
        logic [brbf_pkg::FILL_W-1:0] fill;
        logic [brbf_pkg::FILL_W-1:0] space;
        logic                        empty;
    } t_result;

    logic                             i_clk;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [brbf_pkg::FILL_W-1:0]      i_cfg_data = '0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic                             o_s_axis_tready;
    logic [brbf_pkg::S_TDATA_W-1:0]   i_s_axis_tdata = '0;
    logic [brbf_pkg::KIND_W-1:0]      i_s_axis_tuser = '0;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b0;
    logic [brbf_pkg::M_TDATA_W-1:0]   o_m_axis_tdata;
    logic [brbf_pkg::M_TUSER_W-1:0]   o_m_axis_tuser;
    logic                             o_m_axis_tlast;

    byte_ring_buffer_fifo_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // ring shadow state
    logic [brbf_pkg::BYTE_W-1:0] ring_mem [RING_DEPTH];
    int                          ring_rd = 0;
    int                          ring_wr = 0;
    logic                        ring_full = 1'b0;
    int                          ring_cfg = RING_DEPTH;

    t_result pending_results [$];
    int      fail_count = 0;
    int      cycle_count = 0;
    int      snd_pct = 0;
    int      rcv_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (rcv_pct == 0) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rcv_pct);
        end
    end

    function automatic int ring_size();
        if (ring_cfg == 0) return 1;
        if (ring_cfg > RING_DEPTH) return RING_DEPTH;
        return ring_cfg;
    endfunction

    function automatic int ring_fill();
        if (ring_full) return ring_size();
        if (ring_wr >= ring_rd) return ring_wr - ring_rd;
        return ring_wr + ring_size() - ring_rd;
    endfunction

    // queue one expected result; level fields reflect the state after the step
    task automatic expect_result(input logic status, input logic [7:0] rbyte,
                                 input logic bvalid, input logic last, input int moved);
        t_result r;
        int      f;
        int      sp;
        f  = ring_fill();
        sp = ring_size() - f;
        r.status = status;
        r.rbyte  = rbyte;
        r.bvalid = bvalid;
        r.last   = last;
        r.moved  = moved[brbf_pkg::CNT_W-1:0];
        r.fill   = f[brbf_pkg::FILL_W-1:0];
        r.space  = sp[brbf_pkg::FILL_W-1:0];
        r.empty  = (f == 0);
        pending_results.push_back(r);
    endtask

    task automatic ring_predict(input logic [brbf_pkg::KIND_W-1:0] kind,
                                input logic [63:0] wdata,
                                input logic [brbf_pkg::WLEN_W-1:0] wlen,
                                input logic [brbf_pkg::CNT_W-1:0] rlen);
        int                          s;
        int                          len;
        int                          n;
        logic [brbf_pkg::BYTE_W-1:0] got [READ_MAX];
        s = ring_size();
        case (kind)
            brbf_pkg::KIND_WRITE: begin
                len = (wlen > WRITE_MAX) ? WRITE_MAX : wlen;
                if (s - ring_fill() < len) begin
                    expect_result(brbf_pkg::STATUS_CAP, '0, 1'b0, 1'b1, 0);
                end else begin
                    for (int i = 0; i < len; i++) begin
                        ring_mem[ring_wr] = wdata[8*i +: 8];
                        ring_wr++;
                        if (ring_wr >= s) ring_wr = 0;
                    end
                    if (len != 0 && ring_wr == ring_rd) ring_full = 1'b1;
                    expect_result(brbf_pkg::STATUS_OK, '0, 1'b0, 1'b1, len);
                end
            end
            brbf_pkg::KIND_READ: begin
                n = (rlen > READ_MAX) ? READ_MAX : rlen;
                if (ring_fill() < n) n = ring_fill();
                if (n == 0) begin
                    expect_result(brbf_pkg::STATUS_OK, '0, 1'b0, 1'b1, 0);
                end else begin
                    for (int i = 0; i < n; i++) begin
                        got[i] = ring_mem[ring_rd];
                        ring_rd++;
                        if (ring_rd >= s) ring_rd = 0;
                    end
                    ring_full = 1'b0;
                    for (int i = 0; i < n; i++)
                        expect_result(brbf_pkg::STATUS_OK, got[i], 1'b1, (i + 1 == n), n);
                end
            end
            default: begin
                if (kind == brbf_pkg::KIND_RESET) begin
                    ring_rd   = 0;
                    ring_wr   = 0;
                    ring_full = 1'b0;
                end
                expect_result(brbf_pkg::STATUS_OK, '0, 1'b0, 1'b1, 0);
            end
        endcase
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.status = o_m_axis_tuser[0];
            got.bvalid = o_m_axis_tuser[1];
            got.last   = o_m_axis_tlast;
            got.rbyte  = o_m_axis_tdata[7:0];
            got.moved  = o_m_axis_tdata[14:8];
            got.fill   = o_m_axis_tdata[25:15];
            got.space  = o_m_axis_tdata[36:26];
            got.empty  = o_m_axis_tdata[37];
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= SHOW_MAX)
                    $display("%0t: unexpected result transfer, byte %h fill %0d",
                             $realtime, got.rbyte, got.fill);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.rbyte !== want.rbyte ||
                    got.bvalid !== want.bvalid || got.last !== want.last ||
                    got.moved !== want.moved || got.fill !== want.fill ||
                    got.space !== want.space || got.empty !== want.empty) begin
                    fail_count++;
                    if (fail_count <= SHOW_MAX) begin
                        $display("%0t: mismatch, st byte bv last mv fill free empty",
                                 $realtime);
                        $display("    exp %b %h %b %b %0d %0d %0d %b",
                                 want.status, want.rbyte, want.bvalid, want.last,
                                 want.moved, want.fill, want.space, want.empty);
                        $display("    act %b %h %b %b %0d %0d %0d %b",
                                 got.status, got.rbyte, got.bvalid, got.last,
                                 got.moved, got.fill, got.space, got.empty);
                    end
                end
            end
        end
    end

    task automatic set_idling(input int snd, input int rcv);
        snd_pct = snd;
        rcv_pct = rcv;
    endtask

    task automatic send_item(input logic [brbf_pkg::KIND_W-1:0] kind,
                             input logic [63:0] wdata,
                             input logic [brbf_pkg::WLEN_W-1:0] wlen,
                             input logic [brbf_pkg::CNT_W-1:0] rlen);
        while (snd_pct != 0 && $urandom_range(99) < snd_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {5'b0, rlen, wlen, wdata};
        i_s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        ring_predict(kind, wdata, wlen, rlen);
    endtask

    task automatic send_write(input logic [63:0] wdata,
                              input logic [brbf_pkg::WLEN_W-1:0] wlen);
        send_item(brbf_pkg::KIND_WRITE, wdata, wlen, '0);
    endtask

    task automatic send_read(input logic [brbf_pkg::CNT_W-1:0] rlen);
        send_item(brbf_pkg::KIND_READ, '0, '0, rlen);
    endtask

    // lets the block go idle: every expected transfer out, plus a short tail
    task automatic wait_all_results();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [brbf_pkg::FILL_W-1:0] size);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= size;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        ring_cfg  = size;
        ring_rd   = 0;
        ring_wr   = 0;
        ring_full = 1'b0;
    endtask

    // reset-time size, empty reads, length saturation, no-op and clear kinds
    task automatic test_reset_state();
        set_idling(0, 0);
        send_read(7'd0);
        send_read(7'd64);
        send_write(64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
        send_write(64'h0123_4567_89AB_CDEF, 4'd0);
        send_write(64'h8877_6655_4433_2211, 4'd8);
        send_item(KIND_UNUSED, 64'hDEAD_BEEF_0000_FFFF, 4'd15, 7'd127);
        send_read(7'd127);
        send_read(7'd1);
        send_write(64'h0000_0000_00A5_5AC3, 4'd3);
        send_item(brbf_pkg::KIND_RESET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 7'd127);
        send_read(7'd5);
        wait_all_results();
    endtask

    // size 0 acts as one byte; full flag, refused writes, wrap at a small size
    task automatic test_size_limits();
        write_size(11'd0);
        send_write(64'h0000_0000_0000_007E, 4'd1);
        send_write(64'h0000_0000_0000_0011, 4'd0);
        send_write(64'h0000_0000_0000_0022, 4'd1);
        send_read(7'd64);
        send_read(7'd64);
        wait_all_results();
        write_size(11'd13);
        send_write(64'h1817_1615_1413_1211, 4'd8);
        send_write(64'h2827_2625_2423_2221, 4'd8);
        send_write(64'h0000_0035_3433_3231, 4'd5);
        send_write(64'h0000_0000_0000_0041, 4'd1);
        send_read(7'd3);
        send_write(64'h0000_0000_0053_5251, 4'd3);
        send_read(7'd127);
        wait_all_results();
    endtask

    // size above the store acts as the full store; full-length reads under stalls
    task automatic test_size_clamp();
        write_size(11'h7FF);
        set_idling(0, 69);
        for (int i = 0; i < 8; i++)
            send_write({$urandom, $urandom}, 4'd8);
        send_write({$urandom, $urandom}, 4'd1);
        send_write({$urandom, $urandom}, 4'd0);
        send_read(7'd64);
        send_read(7'd64);
        wait_all_results();
    endtask

    task automatic random_item();
        int                               pick;
        int                               wl;
        int                               rl;
        logic [brbf_pkg::KIND_W-1:0]      kind;
        logic [brbf_pkg::WLEN_W-1:0]      wlen;
        logic [brbf_pkg::CNT_W-1:0]       rlen;
        pick = $urandom_range(99);
        if (pick < 48)      kind = brbf_pkg::KIND_WRITE;
        else if (pick < 90) kind = brbf_pkg::KIND_READ;
        else if (pick < 95) kind = brbf_pkg::KIND_RESET;
        else                kind = KIND_UNUSED;
        wl = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(WRITE_MAX);
        rl = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(1, 8);
        wlen = wl[brbf_pkg::WLEN_W-1:0];
        rlen = rl[brbf_pkg::CNT_W-1:0];
        send_item(kind, {$urandom, $urandom}, wlen, rlen);
    endtask

    task automatic test_random_traffic();
        int sizes [4];
        int snd [4];
        int rcv [4];
        sizes = '{$urandom_range(2, 20), $urandom_range(1, 8), RING_DEPTH,
                  $urandom_range(9, 64)};
        snd   = '{0, 69, 0, 21};
        rcv   = '{0, 0, 69, 21};
        for (int p = 0; p < 4; p++) begin
            write_size(sizes[p][brbf_pkg::FILL_W-1:0]);
            set_idling(snd[p], rcv[p]);
            for (int i = 0; i < 29; i++) begin
                // hold the sender once until the output side has caught up
                if (p == 2 && i == 14) begin
                    i_s_axis_tvalid <= 1'b0;
                    while (pending_results.size() != 0) @(posedge i_clk);
                end
                random_item();
            end
            wait_all_results();
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_size_limits();
        test_size_clamp();
        test_random_traffic();
        set_idling(0, 0);
        wait_all_results();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/brbf_pkg.sv
design/brbf_ram.sv
design/byte_ring_buffer_fifo_unit.sv
design/brbf_checker.sv
verif/tb_byte_ring_buffer_fifo_unit.sv
